>>> rtl/avt_pkg.sv
`default_nettype none

package avt_pkg;

	// Defaults for the top-level parameters
	localparam int TURN_BITS_DEF = 16;
	localparam int CPT_LOG2_DEF  = 12;
	localparam int ANG_W_DEF     = TURN_BITS_DEF + CPT_LOG2_DEF;

	// Fixed field widths
	localparam int CMD_W      = 2;
	localparam int RAW_W      = 12;
	localparam int STATUS_W   = 8;
	localparam int INTERVAL_W = 20;
	localparam int ALPHA_W    = 16;
	localparam int ALPHA_FRAC = 15;
	localparam int VEL_W      = 32;

	// Microseconds per second and the width that holds it
	localparam int US_PER_S = 1000000;
	localparam int US_W     = 20;

	localparam int MAGNET_BIT = 5;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(32768);

	typedef enum logic [CMD_W-1:0] {
		CMD_UPDATE = 2'd0,
		CMD_ZERO   = 2'd1,
		CMD_INIT   = 2'd2
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EVAL,
		S_UNWRAP,
		S_PROD,
		S_DIV,
		S_VINST,
		S_MLOAD,
		S_MUL,
		S_FILT,
		S_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_item;
		logic apply_update;
		logic apply_zero;
		logic apply_init;
		logic unwrap;
		logic prod;
		logic div_step;
		logic vinst;
		logic mload;
		logic mul_step;
		logic filt;
		logic out_load;
		logic out_updated;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             angle_ok;
		logic             interval_zero;
	} dp_status_t;

endpackage

`default_nettype wire

>>> rtl/avt_if.sv
`default_nettype none

interface avt_in_if import avt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CMD_W-1:0]      cmd;
	logic [RAW_W-1:0]      raw_angle;
	logic                  angle_read_ok;
	logic [STATUS_W-1:0]   status_byte;
	logic                  status_read_ok;
	logic [INTERVAL_W-1:0] interval_us;

	modport source (output valid, cmd, raw_angle, angle_read_ok, status_byte,
		status_read_ok, interval_us, input ready);
	modport sink (input valid, cmd, raw_angle, angle_read_ok, status_byte,
		status_read_ok, interval_us, output ready);
endinterface

interface avt_out_if import avt_pkg::*; #(parameter int ANG_W = ANG_W_DEF) ();
	logic                    valid;
	logic                    ready;
	logic signed [ANG_W-1:0] angle_counts;
	logic signed [VEL_W-1:0] velocity;
	logic                    magnet_ok;
	logic                    updated;

	modport source (output valid, angle_counts, velocity, magnet_ok, updated,
		input ready);
	modport sink (input valid, angle_counts, velocity, magnet_ok, updated,
		output ready);
endinterface

interface avt_cfg_if import avt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ALPHA_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

>>> rtl/avt_div.sv
`default_nettype none

// Restoring divider, one quotient bit per step
module avt_div import avt_pkg::*; #(
	parameter int NUM_W = CPT_LOG2_DEF + US_W
) (
	input  wire logic                  clk,
	input  wire logic                  load,
	input  wire logic                  step,
	input  wire logic [NUM_W-1:0]      dividend,
	input  wire logic [INTERVAL_W-1:0] divisor,
	output logic      [NUM_W-1:0]      quotient
);

	logic [INTERVAL_W-1:0] rem_q;
	logic [NUM_W-1:0]      quo_q;
	logic [INTERVAL_W:0]   shifted;
	logic                  fits;
	logic [INTERVAL_W-1:0] rem_d;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign fits    = shifted >= {1'b0, divisor};

	always_comb begin
		if (fits) begin
			rem_d = INTERVAL_W'(shifted - {1'b0, divisor});
		end else begin
			rem_d = shifted[INTERVAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (step) begin
			rem_q <= rem_d;
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> rtl/avt_dpath.sv
`default_nettype none

module avt_dpath import avt_pkg::*; #(
	parameter int TURN_BITS = TURN_BITS_DEF,
	parameter int CPT_LOG2  = CPT_LOG2_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire ctrl_cmd_t                         cmd,
	output dp_status_t                             status,
	input  wire logic                              cfg_write,
	input  wire logic [ALPHA_W-1:0]                cfg_data,
	input  wire logic [CMD_W-1:0]                  item_cmd,
	input  wire logic [RAW_W-1:0]                  raw_angle,
	input  wire logic                              angle_read_ok,
	input  wire logic [STATUS_W-1:0]               status_byte,
	input  wire logic                              status_read_ok,
	input  wire logic [INTERVAL_W-1:0]             interval_us,
	output logic signed [TURN_BITS+CPT_LOG2-1:0]   angle_counts,
	output logic signed [VEL_W-1:0]                velocity,
	output logic                                   magnet_ok,
	output logic                                   updated
);

	localparam int RD_W  = CPT_LOG2;
	localparam int ANG_W = TURN_BITS + CPT_LOG2;
	localparam int D_W   = RD_W + 1;
	localparam int NUM_W = RD_W + US_W;
	localparam int VI_W  = NUM_W + 1;
	localparam int VD_W  = ((VI_W > VEL_W) ? VI_W : VEL_W) + 1;
	localparam int P_W   = VD_W + ALPHA_W;
	localparam int FL_W  = P_W - ALPHA_FRAC;
	localparam int VN_W  = FL_W + 1;

	localparam logic [RD_W-1:0]            HALF_U     = RD_W'(2 ** (RD_W - 1));
	localparam logic signed [D_W-1:0]      HALF_D     = D_W'(2 ** (RD_W - 1));
	localparam logic signed [D_W-1:0]      NEG_HALF_D = -HALF_D;
	localparam logic signed [TURN_BITS-1:0] TURN_MAX_C = {1'b0, {(TURN_BITS-1){1'b1}}};
	localparam logic signed [TURN_BITS-1:0] TURN_MIN_C = {1'b1, {(TURN_BITS-1){1'b0}}};
	localparam logic signed [VEL_W-1:0]    VEL_MAX_C  = {1'b0, {(VEL_W-1){1'b1}}};
	localparam logic signed [VEL_W-1:0]    VEL_MIN_C  = {1'b1, {(VEL_W-1){1'b0}}};
	localparam logic signed [VN_W-1:0]     VN_MAX     = VN_W'(VEL_MAX_C);
	localparam logic signed [VN_W-1:0]     VN_MIN     = VN_W'(VEL_MIN_C);

	// Latched request
	logic [CMD_W-1:0]      cmd_q;
	logic [RD_W-1:0]       raw_q;
	logic                  angle_ok_q;
	logic                  mag_in_q;
	logic                  status_ok_q;
	logic [INTERVAL_W-1:0] interval_q;

	// Architectural state
	logic [ALPHA_W-1:0]          alpha_q;
	logic [RD_W-1:0]             zero_q;
	logic [RD_W-1:0]             prev_rd_q;
	logic signed [TURN_BITS-1:0] turn_q;
	logic signed [ANG_W-1:0]     prev_unw_q;
	logic signed [VEL_W-1:0]     vel_q;
	logic signed [ANG_W-1:0]     angle_q;
	logic                        magnet_q;

	// Work registers
	logic signed [D_W-1:0]  d_q;
	logic                   neg_q;
	logic signed [VI_W-1:0] vinst_q;
	logic signed [P_W-1:0]  mcand_q;
	logic [ALPHA_W-1:0]     mult_q;
	logic signed [P_W-1:0]  acc_q;

	// Result register
	logic signed [ANG_W-1:0] out_angle_q;
	logic signed [VEL_W-1:0] out_vel_q;
	logic                    out_mag_q;
	logic                    out_upd_q;

	logic signed [D_W-1:0]       rd_diff;
	logic signed [TURN_BITS-1:0] turn_d;
	logic signed [ANG_W-1:0]     unw;
	logic signed [ANG_W:0]       du;
	logic [RD_W-1:0]             du_m;
	logic signed [D_W-1:0]       d_wrap;
	logic [D_W-1:0]              d_abs;
	logic [NUM_W-1:0]            prod;
	logic [NUM_W-1:0]            quo;
	logic signed [VD_W-1:0]      fdiff;
	logic [ALPHA_W-1:0]          alpha_eff;
	logic signed [FL_W-1:0]      fl;
	logic signed [VN_W-1:0]      vn;
	logic signed [VEL_W-1:0]     vel_sat;

	assign status.cmd           = cmd_q;
	assign status.angle_ok      = angle_ok_q;
	assign status.interval_zero = (interval_q == '0);

	// Turn step from the raw jump
	assign rd_diff = $signed({1'b0, raw_q}) - $signed({1'b0, prev_rd_q});

	always_comb begin
		turn_d = turn_q;
		if (rd_diff > HALF_D && turn_q != TURN_MIN_C) begin
			turn_d = turn_q - TURN_BITS'(1);
		end else if (rd_diff < NEG_HALF_D && turn_q != TURN_MAX_C) begin
			turn_d = turn_q + TURN_BITS'(1);
		end
	end

	// Unwrapped angle never leaves range, so it is a plain concatenation
	assign unw  = $signed({turn_q, raw_q});
	assign du   = $signed({unw[ANG_W-1], unw}) - $signed({prev_unw_q[ANG_W-1], prev_unw_q});
	assign du_m = du[RD_W-1:0];

	always_comb begin
		if (du_m == HALF_U) begin
			d_wrap = du[ANG_W] ? NEG_HALF_D : HALF_D;
		end else if (du_m > HALF_U) begin
			d_wrap = $signed({1'b1, du_m});
		end else begin
			d_wrap = $signed({1'b0, du_m});
		end
	end

	assign d_abs = d_q[D_W-1] ? D_W'(-d_q) : D_W'(d_q);
	assign prod  = NUM_W'(d_abs[RD_W-1:0]) * NUM_W'(US_PER_S);

	avt_div #(
		.NUM_W (NUM_W)
	) u_div (
		.clk      (clk),
		.load     (cmd.prod),
		.step     (cmd.div_step),
		.dividend (prod),
		.divisor  (interval_q),
		.quotient (quo)
	);

	assign alpha_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign fdiff     = VD_W'(vinst_q) - VD_W'(vel_q);

	// Arithmetic shift of the product gives the floor
	assign fl = $signed(acc_q[P_W-1:ALPHA_FRAC]);
	assign vn = VN_W'(vel_q) + VN_W'(fl);

	always_comb begin
		if (vn > VN_MAX) begin
			vel_sat = VEL_MAX_C;
		end else if (vn < VN_MIN) begin
			vel_sat = VEL_MIN_C;
		end else begin
			vel_sat = vn[VEL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q    <= ALPHA_ONE;
			zero_q     <= '0;
			prev_rd_q  <= '0;
			turn_q     <= '0;
			prev_unw_q <= '0;
			vel_q      <= '0;
			angle_q    <= '0;
			magnet_q   <= 1'b0;
		end else begin
			if (cfg_write) begin
				alpha_q <= cfg_data;
			end
			if (cmd.apply_update) begin
				turn_q    <= turn_d;
				prev_rd_q <= raw_q;
				if (status_ok_q) begin
					magnet_q <= mag_in_q;
				end
			end
			if (cmd.apply_zero) begin
				zero_q     <= raw_q;
				prev_rd_q  <= raw_q;
				turn_q     <= '0;
				angle_q    <= '0;
				vel_q      <= '0;
				prev_unw_q <= ANG_W'(raw_q);
			end
			if (cmd.apply_init) begin
				zero_q     <= '0;
				prev_rd_q  <= angle_ok_q ? raw_q : '0;
				turn_q     <= '0;
				prev_unw_q <= angle_ok_q ? ANG_W'(raw_q) : '0;
				vel_q      <= '0;
				angle_q    <= '0;
				magnet_q   <= status_ok_q & mag_in_q;
			end
			if (cmd.unwrap) begin
				prev_unw_q <= unw;
				angle_q    <= $signed({turn_q, RD_W'(raw_q - zero_q)});
			end
			if (cmd.filt) begin
				vel_q <= vel_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			cmd_q       <= item_cmd;
			raw_q       <= RD_W'(raw_angle);
			angle_ok_q  <= angle_read_ok;
			mag_in_q    <= status_byte[MAGNET_BIT];
			status_ok_q <= status_read_ok;
			interval_q  <= interval_us;
		end
		if (cmd.unwrap) begin
			d_q <= d_wrap;
		end
		if (cmd.prod) begin
			neg_q <= d_q[D_W-1];
		end
		if (cmd.vinst) begin
			vinst_q <= neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		end
		if (cmd.mload) begin
			mcand_q <= P_W'(fdiff);
			mult_q  <= alpha_eff;
			acc_q   <= '0;
		end else if (cmd.mul_step) begin
			if (mult_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q <= mcand_q <<< 1;
			mult_q  <= mult_q >> 1;
		end
		if (cmd.out_load) begin
			out_angle_q <= angle_q;
			out_vel_q   <= vel_q;
			out_mag_q   <= magnet_q;
			out_upd_q   <= cmd.out_updated;
		end
	end

	assign angle_counts = out_angle_q;
	assign velocity     = out_vel_q;
	assign magnet_ok    = out_mag_q;
	assign updated      = out_upd_q;

endmodule

`default_nettype wire

>>> rtl/avt_ctrl.sv
`default_nettype none

module avt_ctrl import avt_pkg::*; #(
	parameter int CPT_LOG2 = CPT_LOG2_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	localparam int NUM_W    = CPT_LOG2 + US_W;
	localparam int ITER_MAX = (NUM_W > ALPHA_W) ? NUM_W : ALPHA_W;
	localparam int CNT_W    = $clog2(ITER_MAX);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             upd_q, upd_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			upd_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			upd_q   <= upd_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		upd_d    = upd_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_EVAL;
				end
			end
			S_EVAL: begin
				state_d = S_DONE;
				upd_d   = 1'b0;
				unique case (status.cmd)
					CMD_UPDATE: begin
						if (status.angle_ok && !status.interval_zero) begin
							cmd.apply_update = 1'b1;
							upd_d            = 1'b1;
							state_d          = S_UNWRAP;
						end
					end
					CMD_ZERO: begin
						if (status.angle_ok) begin
							cmd.apply_zero = 1'b1;
							upd_d          = 1'b1;
						end
					end
					CMD_INIT: begin
						cmd.apply_init = 1'b1;
						upd_d          = 1'b1;
					end
					default: upd_d = 1'b0;
				endcase
			end
			S_UNWRAP: begin
				cmd.unwrap = 1'b1;
				state_d    = S_PROD;
			end
			S_PROD: begin
				cmd.prod = 1'b1;
				cnt_d    = CNT_W'(NUM_W - 1);
				state_d  = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					state_d = S_VINST;
				end
			end
			S_VINST: begin
				cmd.vinst = 1'b1;
				state_d   = S_MLOAD;
			end
			S_MLOAD: begin
				cmd.mload = 1'b1;
				cnt_d     = CNT_W'(ALPHA_W - 1);
				state_d   = S_MUL;
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				cnt_d        = cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					state_d = S_FILT;
				end
			end
			S_FILT: begin
				cmd.filt = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				cmd.out_updated = upd_q;
				// hold until the result slot is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	a_accept_evals: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == S_EVAL)
		else $error("accepted request did not move to evaluation");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROD) |=> (state_q == S_DIV && cnt_q == CNT_W'(NUM_W - 1)))
		else $error("divider did not start with a full iteration count");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !out_ready) |=> state_q == S_DONE)
		else $error("result dropped while the slot was occupied");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result raised outside the completion state");

endmodule

`default_nettype wire

>>> rtl/angle_unwrap_velocity_tracker_top.sv
`default_nettype none

// Channel   Role     Payload
// cfg       sink     data: filter weight, Q1.15, above 1.0 acts as 1.0
// sample    sink     cmd, raw_angle, angle_read_ok, status_byte, status_read_ok,
//                    interval_us
// result    source   angle_counts, velocity, magnet_ok, updated
//
// An update request runs the serial divider, one quotient bit at a time
// (CPT_LOG2 + 20 bits), then the filter multiplier, one weight bit at a time
// (16), before the next request is accepted. Set zero, initialize and
// skipped requests skip both and go straight to completion.
// Reset clears the controller, the tracking state and loads the weight as 1.0.
// A finished result sits in the output register; the next request is accepted
// while it waits, and only the completion of that next request stalls on it.
module angle_unwrap_velocity_tracker_top import avt_pkg::*; #(
	parameter int TURN_BITS = TURN_BITS_DEF,
	parameter int CPT_LOG2  = CPT_LOG2_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	avt_cfg_if.sink   cfg,
	avt_in_if.sink    sample,
	avt_out_if.source result
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Register writes never stall
	assign cfg.ready = 1'b1;

	// Sequence each request: decode, then for updates unwrap, divide and filter, then complete
	avt_ctrl #(
		.CPT_LOG2 (CPT_LOG2)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Hold the tracking state, the arithmetic and the result register
	avt_dpath #(
		.TURN_BITS (TURN_BITS),
		.CPT_LOG2  (CPT_LOG2)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_write      (cfg.valid),
		.cfg_data       (cfg.data),
		.item_cmd       (sample.cmd),
		.raw_angle      (sample.raw_angle),
		.angle_read_ok  (sample.angle_read_ok),
		.status_byte    (sample.status_byte),
		.status_read_ok (sample.status_read_ok),
		.interval_us    (sample.interval_us),
		.angle_counts   (result.angle_counts),
		.velocity       (result.velocity),
		.magnet_ok      (result.magnet_ok),
		.updated        (result.updated)
	);

endmodule

`default_nettype wire

>>> tb/sv/tb_angle_unwrap_velocity_tracker_top.sv
`default_nettype none

module tb_angle_unwrap_velocity_tracker_top import avt_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     ANG_W       = ANG_W_DEF;
	localparam longint CPT         = longint'(1) << CPT_LOG2_DEF;
	localparam longint HALF_TURN   = CPT / 2;
	localparam longint TURN_HI     = (longint'(1) << (TURN_BITS_DEF - 1)) - 1;
	localparam longint TURN_LO     = -(longint'(1) << (TURN_BITS_DEF - 1));
	localparam longint ANG_HI      = (longint'(1) << (ANG_W - 1)) - 1;
	localparam longint ANG_LO      = -(longint'(1) << (ANG_W - 1));
	localparam longint VEL_HI      = 64'sd2147483647;
	localparam longint VEL_LO      = -64'sd2147483648;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int     HOLD_CYCLES = 600;
	localparam int     PHASE_ITEMS = 322;
	localparam int     NUM_PHASES  = 6;
	localparam int     MAX_PRINTS  = 50;

	// One sensor sample request and one tracker result
	typedef struct {
		logic [CMD_W-1:0]      cmd;
		logic [RAW_W-1:0]      raw;
		logic                  angle_ok;
		logic [STATUS_W-1:0]   status;
		logic                  status_ok;
		logic [INTERVAL_W-1:0] interval;
	} sensor_req_t;

	typedef struct {
		logic signed [ANG_W-1:0] angle;
		logic signed [VEL_W-1:0] velocity;
		logic                    magnet;
		logic                    updated;
	} tracker_out_t;

	// Tracks the unwrapper state alongside the block and holds the results it
	// should produce, oldest first.
	class angle_velocity_scoreboard;
		logic [ALPHA_W-1:0]              alpha;
		logic [RAW_W-1:0]                zero_reading;
		logic [RAW_W-1:0]                last_reading;
		logic signed [TURN_BITS_DEF-1:0] turns;
		logic signed [ANG_W-1:0]         last_unwrapped;
		logic signed [ANG_W-1:0]         angle;
		logic signed [VEL_W-1:0]         velocity;
		logic                            magnet;
		tracker_out_t                    pending_results[$];
		int n_errors, n_checked, n_moved, n_held, n_turns, n_half;

		function new();
			alpha = ALPHA_ONE;
			clear_tracking();
			n_errors  = 0;
			n_checked = 0;
			n_moved   = 0;
			n_held    = 0;
			n_turns   = 0;
			n_half    = 0;
		endfunction

		// Everything but the filter weight
		function void clear_tracking();
			zero_reading   = '0;
			last_reading   = '0;
			turns          = '0;
			last_unwrapped = '0;
			angle          = '0;
			velocity       = '0;
			magnet         = 1'b0;
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			if (v < lo) return lo;
			if (v > hi) return hi;
			return v;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void note_request(sensor_req_t r);
			longint       step_raw, unwrapped, delta, rem, v_inst, weight, v_next, offset;
			tracker_out_t res;
			logic         moved;
			moved = 1'b0;
			case (r.cmd)
			CMD_INIT: begin
				clear_tracking();
				if (r.angle_ok) begin
					last_reading   = r.raw;
					last_unwrapped = r.raw;
				end
				if (r.status_ok)
					magnet = r.status[MAGNET_BIT];
				moved = 1'b1;
			end
			CMD_ZERO: begin
				if (r.angle_ok) begin
					zero_reading   = r.raw;
					last_reading   = r.raw;
					turns          = '0;
					angle          = '0;
					velocity       = '0;
					last_unwrapped = r.raw;
					moved          = 1'b1;
				end
			end
			CMD_UPDATE: begin
				if (r.angle_ok && r.interval != '0) begin
					// a jump of more than half a turn crosses the index
					step_raw = longint'(r.raw) - longint'(last_reading);
					if (step_raw > HALF_TURN && turns > TURN_LO) begin
						turns--;
						n_turns++;
					end
					if (step_raw < -HALF_TURN && turns < TURN_HI) begin
						turns++;
						n_turns++;
					end
					last_reading = r.raw;
					unwrapped = clamp(longint'(r.raw) + longint'(turns) * CPT, ANG_LO, ANG_HI);
					// wrap to [-half, +half]; exactly half keeps its sign
					delta = unwrapped - longint'(last_unwrapped);
					rem = delta % CPT;
					if (rem < 0)
						rem += CPT;
					if (rem == HALF_TURN) begin
						delta = (delta < 0) ? -HALF_TURN : HALF_TURN;
						n_half++;
					end else begin
						delta = (rem > HALF_TURN) ? rem - CPT : rem;
					end
					last_unwrapped = unwrapped;
					v_inst = (delta * US_PER_S) / longint'(r.interval);
					weight = (alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha);
					v_next = longint'(velocity)
						+ ((weight * (v_inst - longint'(velocity))) >>> ALPHA_FRAC);
					velocity = clamp(v_next, VEL_LO, VEL_HI);
					offset = longint'(r.raw) - longint'(zero_reading);
					if (offset < 0)
						offset += CPT;
					angle = clamp(offset + longint'(turns) * CPT, ANG_LO, ANG_HI);
					if (r.status_ok)
						magnet = r.status[MAGNET_BIT];
					moved = 1'b1;
				end
			end
			default: ;
			endcase
			if (moved)
				n_moved++;
			else
				n_held++;
			res.angle    = angle;
			res.velocity = velocity;
			res.magnet   = magnet;
			res.updated  = moved;
			pending_results.push_back(res);
		endfunction

		task report_mismatch(string field, longint got, longint want);
			n_errors++;
			if (n_errors <= MAX_PRINTS)
				$display("[%0t] result %0d: %s is %0d, should be %0d",
					$time, n_checked, field, got, want);
		endtask

		task check_result(tracker_out_t got);
			tracker_out_t want;
			n_checked++;
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request outstanding, angle", got.angle, 0);
				return;
			end
			want = pending_results.pop_front();
			if (got.angle !== want.angle)
				report_mismatch("angle_counts", got.angle, want.angle);
			if (got.velocity !== want.velocity)
				report_mismatch("velocity", got.velocity, want.velocity);
			if (got.magnet !== want.magnet)
				report_mismatch("magnet_ok", got.magnet, want.magnet);
			if (got.updated !== want.updated)
				report_mismatch("updated", got.updated, want.updated);
		endtask
	endclass

	logic clk;
	logic arst_n;

	avt_cfg_if                    cfg_ch();
	avt_in_if                     smp_ch();
	avt_out_if #(.ANG_W(ANG_W))   res_ch();

	angle_unwrap_velocity_tracker_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.sample (smp_ch),
		.result (res_ch)
	);

	angle_velocity_scoreboard tracker;

	// Idle control shared by both sides; hold_req asks the result side for one
	// long hold-off, which it counts out on its own.
	bit               idle_on  = 1'b1;
	bit               hold_req = 1'b0;
	logic [RAW_W-1:0] walk_raw = '0;
	int               spin_dir = 1;
	int               n_alpha_writes = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#8_000_000;
		$display("FAIL");
		$finish;
	end

	// Build one request from its fields
	function automatic sensor_req_t make_req(logic [CMD_W-1:0] cmd, int raw, bit angle_ok,
		int status, bit status_ok, int interval);
		sensor_req_t r;
		r.cmd       = cmd;
		r.raw       = RAW_W'(raw);
		r.angle_ok  = angle_ok;
		r.status    = STATUS_W'(status);
		r.status_ok = status_ok;
		r.interval  = INTERVAL_W'(interval);
		return r;
	endfunction

	// Random request: mostly good updates that follow a moving shaft, the rest
	// commands, failed reads, zero intervals and wild jumps.
	function automatic sensor_req_t random_req(bit spin);
		sensor_req_t r;
		int          pick, step;
		if (spin) begin
			// turn steadily so the turn count builds up
			step = spin_dir * int'($urandom_range(600, 2040));
			if ($urandom_range(0, 199) == 0)
				spin_dir = -spin_dir;
		end else begin
			case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: step = int'($urandom_range(0, 400)) - 200;
			5, 6:          step = int'($urandom_range(0, 4094)) - 2047;
			7:             step = ($urandom_range(0, 1) ? 1 : -1)
					* (2047 + int'($urandom_range(0, 2)));
			default:       step = int'($urandom_range(0, 4095));
			endcase
		end
		walk_raw    = RAW_W'(int'(walk_raw) + step);
		r.cmd       = CMD_UPDATE;
		r.raw       = walk_raw;
		r.angle_ok  = 1'b1;
		r.status    = STATUS_W'($urandom);
		r.status_ok = ($urandom_range(0, 9) != 0);
		case ($urandom_range(0, 19))
		0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11:
			r.interval = INTERVAL_W'($urandom_range(1, 2000));
		12, 13, 14, 15, 16:
			r.interval = INTERVAL_W'($urandom_range(1, 1000000));
		17, 18:
			r.interval = INTERVAL_W'($urandom);
		default:
			r.interval = '0;
		endcase
		pick = $urandom_range(0, 99);
		if (pick >= 95) begin
			r.raw      = RAW_W'($urandom);
			r.angle_ok = 1'($urandom_range(0, 1));
		end else if (pick >= 92) begin
			r.cmd      = CMD_UNUSED;
			r.angle_ok = 1'($urandom_range(0, 1));
		end else if (pick >= 89) begin
			r.cmd      = CMD_INIT;
			r.angle_ok = ($urandom_range(0, 3) != 0);
		end else if (pick >= 85) begin
			r.cmd      = CMD_ZERO;
			r.angle_ok = ($urandom_range(0, 5) != 0);
		end else if (pick >= 80) begin
			r.angle_ok = 1'b0;
		end
		return r;
	endfunction

	// Offer one request; change inputs on the falling edge, take the handshake
	// on the rising one. Returns right after the edge that accepted it.
	task automatic send_sample(sensor_req_t r);
		@(negedge clk);
		while (idle_on && $urandom_range(0, 99) < 34) begin
			smp_ch.valid <= 1'b0;
			@(negedge clk);
		end
		smp_ch.valid          <= 1'b1;
		smp_ch.cmd            <= r.cmd;
		smp_ch.raw_angle      <= r.raw;
		smp_ch.angle_read_ok  <= r.angle_ok;
		smp_ch.status_byte    <= r.status;
		smp_ch.status_read_ok <= r.status_ok;
		smp_ch.interval_us    <= r.interval;
		do @(posedge clk); while (!smp_ch.ready);
		tracker.note_request(r);
	endtask

	// Write the filter weight; only called while the block is idle
	task automatic write_alpha(logic [ALPHA_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		tracker.alpha = value;
		n_alpha_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Drop the request line and wait until every result is back
	task automatic drain_results();
		@(negedge clk);
		smp_ch.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Result side: random stalls, plus one long hold-off on request so the
	// block fills its output register and pushes back on the sample side.
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				res_ch.ready <= !(idle_on && $urandom_range(0, 99) < 34);
			end
		end
	end

	// Check every result on the edge that takes it
	always @(posedge clk) begin
		tracker_out_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.angle    = res_ch.angle_counts;
			got.velocity = res_ch.velocity;
			got.magnet   = res_ch.magnet_ok;
			got.updated  = res_ch.updated;
			tracker.check_result(got);
		end
	end

	initial begin
		logic [ALPHA_W-1:0] phase_alpha [NUM_PHASES];

		// Known values on every input from time zero
		arst_n                = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.data           = '0;
		smp_ch.valid          = 1'b0;
		smp_ch.cmd            = CMD_UPDATE;
		smp_ch.raw_angle      = '0;
		smp_ch.angle_read_ok  = 1'b0;
		smp_ch.status_byte    = '0;
		smp_ch.status_read_ok = 1'b0;
		smp_ch.interval_us    = '0;
		tracker = new();

		// Weight per random phase: off, above 1.0, smallest step, half, just
		// under 1.0, then anything.
		phase_alpha[0] = '0;
		phase_alpha[1] = '1;
		phase_alpha[2] = ALPHA_W'(1);
		phase_alpha[3] = ALPHA_W'(16384);
		phase_alpha[4] = ALPHA_W'(32767);
		phase_alpha[5] = ALPHA_W'($urandom_range(0, 65535));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_alpha(ALPHA_ONE);

		// Directed: exact half turns both ways, crossings, extreme intervals,
		// skipped updates, status kept on a failed read, zero and init with
		// and without a good read, and the unused command.
		send_sample(make_req(CMD_INIT,   0,    1, 'h20, 1, 0));
		send_sample(make_req(CMD_UPDATE, 2048, 1, 'hFF, 1, 1));
		send_sample(make_req(CMD_UPDATE, 0,    1, 'h00, 1, 1));
		send_sample(make_req(CMD_UPDATE, 4095, 1, 'h20, 0, 1000000));
		send_sample(make_req(CMD_UPDATE, 0,    1, 'hDF, 1, 'hFFFFF));
		send_sample(make_req(CMD_UPDATE, 1,    1, 'h20, 1, 0));
		send_sample(make_req(CMD_UPDATE, 5,    0, 'h20, 1, 10));
		send_sample(make_req(CMD_UPDATE, 100,  1, 'h20, 1, 1000));
		send_sample(make_req(CMD_ZERO,   4095, 1, 'h00, 1, 0));
		send_sample(make_req(CMD_ZERO,   7,    0, 'h00, 1, 5));
		send_sample(make_req(CMD_UPDATE, 0,    1, 'hFF, 0, 500));
		send_sample(make_req(CMD_UNUSED, 123,  1, 'h00, 1, 50));
		send_sample(make_req(CMD_INIT,   77,   0, 'hFF, 0, 0));
		send_sample(make_req(CMD_INIT,   4095, 1, 'h20, 1, 'hFFFFF));
		send_sample(make_req(CMD_UPDATE, 2047, 1, 'h20, 1, 3));
		send_sample(make_req(CMD_UPDATE, 4095, 1, 'h20, 1, 7));
		send_sample(make_req(CMD_UPDATE, 2046, 1, 'h20, 1, 1));
		send_sample(make_req(CMD_UNUSED, 4095, 0, 'hFF, 0, 0));
		send_sample(make_req(CMD_UPDATE, 4094, 1, 'h00, 0, 2));

		// Random phases, each with its own weight written while idle
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_results();
			write_alpha(phase_alpha[p]);
			idle_on = (p != 3);
			// hold the result side off right at the start of one phase
			if (p == 1)
				hold_req = 1'b1;
			repeat (PHASE_ITEMS)
				send_sample(random_req(p == 2 || p == 4));
		end
		idle_on = 1'b1;

		// Wait for the tail, then give the block a full update time to show
		// any stray result.
		drain_results();
		repeat (60) @(posedge clk);

		$display("Checked %0d results for %0d requests: %0d moved the state, %0d held.",
			tracker.n_checked, tracker.n_moved + tracker.n_held,
			tracker.n_moved, tracker.n_held);
		$display("Saw %0d turn crossings, %0d exact half-turn steps, %0d weight writes.",
			tracker.n_turns, tracker.n_half, n_alpha_writes);
		if (tracker.n_errors == 0 && tracker.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
rtl/avt_pkg.sv
rtl/avt_if.sv
rtl/avt_div.sv
rtl/avt_dpath.sv
rtl/avt_ctrl.sv
rtl/angle_unwrap_velocity_tracker_top.sv
tb/sv/tb_angle_unwrap_velocity_tracker_top.sv
